/* hw/rtl/nfpa_pkg.sv */
// nfpa_pkg: shared types, codes and field widths of the next-fit partition allocator
// no dependencies; imported by the interfaces and by every rtl module but nfpa_ram
`default_nettype none

package nfpa_pkg;

  // field widths of one input and one result transaction
  localparam int ACT_W  = 2;
  localparam int LEN_W  = 8;
  localparam int RIDX_W = 6;
  localparam int ST_W   = 2;
  localparam int WORD_W = 2 * LEN_W;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // used length saturates here
  localparam logic [LEN_W-1:0] USED_MAX = 8'hFF;

  // controller to datapath
  typedef struct packed {
    logic            capture;
    logic            clear;
    logic            append;
    logic            res_err;
    logic [ST_W-1:0] err_code;
    logic            rd_issue;
    logic            rd_take;
    logic            scan_start;
    logic            scan_step;
    logic            push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             full;
    logic             empty;
    logic             range_bad;
    logic             scan_hit;
    logic             scan_miss;
    logic             out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/nfpa_if.sv */
// nfpa_in_if / nfpa_out_if: valid-ready channels for action and result transactions
// depends on nfpa_pkg for field widths
`default_nettype none

interface nfpa_in_if;
  import nfpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [LEN_W-1:0]  new_free_len;
  logic [LEN_W-1:0]  new_used_len;
  logic [LEN_W-1:0]  request_size;
  logic [RIDX_W-1:0] read_index;

  modport source (output valid, action, new_free_len, new_used_len, request_size,
                  read_index, input ready);
  modport sink (input valid, action, new_free_len, new_used_len, request_size,
                read_index, output ready);
endinterface

interface nfpa_out_if;
  import nfpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [RIDX_W-1:0] entry_index;
  logic [LEN_W-1:0]  entry_free_len;
  logic [LEN_W-1:0]  entry_used_len;

  modport source (output valid, status, entry_index, entry_free_len, entry_used_len,
                  input ready);
  modport sink (input valid, status, entry_index, entry_free_len, entry_used_len,
                output ready);
endinterface

`default_nettype wire

/* hw/rtl/nfpa_ram.sv */
// nfpa_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module nfpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/nfpa_ctrl.sv */
// nfpa_ctrl: sequencer that steps one transaction through decode, table access and output
// depends on nfpa_pkg for cmd_t, sts_t and the action and status codes
`default_nettype none

module nfpa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire nfpa_pkg::sts_t sts,
  output nfpa_pkg::cmd_t      cmd
);
  import nfpa_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_PUSH   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_PUSH;
        case (sts.action)
          ACT_CLEAR: begin
            cmd.clear = 1'b1;
          end
          ACT_APPEND: begin
            if (sts.full) begin
              cmd.res_err  = 1'b1;
              cmd.err_code = ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end
          ACT_ALLOC: begin
            if (sts.empty) begin
              cmd.res_err  = 1'b1;
              cmd.err_code = ST_NOFIT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          ACT_READ: begin
            if (sts.range_bad) begin
              cmd.res_err  = 1'b1;
              cmd.err_code = ST_RANGE;
            end else begin
              cmd.rd_issue = 1'b1;
              state_nxt    = S_RDWAIT;
            end
          end
          default: begin
            cmd.res_err  = 1'b1;
            cmd.err_code = ST_RANGE;
          end
        endcase
      end
      S_RDWAIT: begin
        cmd.rd_take = 1'b1;
        state_nxt   = S_PUSH;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit || sts.scan_miss) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/nfpa_dp.sv */
// nfpa_dp: partition table, count, rover, next-fit scan pointers and result registers
// depends on nfpa_pkg and nfpa_ram
`default_nettype none

module nfpa_dp #(
  parameter int MAX_PARTS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire nfpa_pkg::cmd_t              cmd,
  output nfpa_pkg::sts_t                   sts,
  input  wire logic [nfpa_pkg::ACT_W-1:0]  in_action,
  input  wire logic [nfpa_pkg::LEN_W-1:0]  in_new_free_len,
  input  wire logic [nfpa_pkg::LEN_W-1:0]  in_new_used_len,
  input  wire logic [nfpa_pkg::LEN_W-1:0]  in_request_size,
  input  wire logic [nfpa_pkg::RIDX_W-1:0] in_read_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [nfpa_pkg::ST_W-1:0]   out_status,
  output logic      [nfpa_pkg::RIDX_W-1:0] out_entry_index,
  output logic      [nfpa_pkg::LEN_W-1:0]  out_entry_free_len,
  output logic      [nfpa_pkg::LEN_W-1:0]  out_entry_used_len
);
  import nfpa_pkg::*;

  localparam int IW = $clog2(MAX_PARTS);
  localparam int CW = $clog2(MAX_PARTS + 1);
  localparam int XW = (CW > RIDX_W) ? CW : RIDX_W;

  // captured transaction
  logic [ACT_W-1:0]  act_r;
  logic [LEN_W-1:0]  nfree_r, nused_r, req_r;
  logic [RIDX_W-1:0] ridx_r;

  // table state and scan state
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] rover_r, rover_nxt;
  logic [IW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] issued_r, issued_nxt;
  logic [IW-1:0] chk_ptr_r, chk_ptr_nxt;
  logic          chk_vld_r, chk_vld_nxt;

  // staged result and output register
  logic [ST_W-1:0]   res_st_r, res_st_nxt;
  logic [IW-1:0]     res_idx_r, res_idx_nxt;
  logic [LEN_W-1:0]  res_free_r, res_free_nxt;
  logic [LEN_W-1:0]  res_used_r, res_used_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_st_r;
  logic [RIDX_W-1:0] out_idx_r;
  logic [LEN_W-1:0]  out_free_r, out_used_r;

  // ram ports
  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [LEN_W-1:0]  rd_free, rd_used;

  // scan arithmetic
  logic              issue;
  logic [CW-1:0]     rd_ptr_inc, chk_ptr_inc;
  logic [LEN_W:0]    used_sum;
  logic [LEN_W-1:0]  used_sat, free_left;

  nfpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_PARTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_free = ram_rdata[WORD_W-1:LEN_W];
  assign rd_used = ram_rdata[LEN_W-1:0];

  assign issue       = (issued_r < count_r);
  assign rd_ptr_inc  = CW'(rd_ptr_r) + CW'(1);
  assign chk_ptr_inc = CW'(chk_ptr_r) + CW'(1);
  assign used_sum    = {1'b0, rd_used} + {1'b0, req_r};
  assign used_sat    = used_sum[LEN_W] ? USED_MAX : used_sum[LEN_W-1:0];
  assign free_left   = rd_free - req_r;

  // status to the controller
  always_comb begin
    sts.action    = act_r;
    sts.full      = (count_r == CW'(MAX_PARTS));
    sts.empty     = (count_r == '0);
    sts.range_bad = (XW'(ridx_r) >= XW'(count_r));
    sts.scan_hit  = chk_vld_r && (rd_free >= req_r);
    sts.scan_miss = !chk_vld_r && (issued_r == count_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // table update, scan stepping and result staging
  always_comb begin
    count_nxt    = count_r;
    rover_nxt    = rover_r;
    rd_ptr_nxt   = rd_ptr_r;
    issued_nxt   = issued_r;
    chk_ptr_nxt  = chk_ptr_r;
    chk_vld_nxt  = 1'b0;
    res_st_nxt   = res_st_r;
    res_idx_nxt  = res_idx_r;
    res_free_nxt = res_free_r;
    res_used_nxt = res_used_r;
    ram_we       = 1'b0;
    ram_waddr    = IW'(count_r);
    ram_wdata    = {nfree_r, nused_r};
    ram_raddr    = rd_ptr_r;

    if (cmd.clear) begin
      count_nxt    = '0;
      rover_nxt    = '0;
      res_st_nxt   = ST_OK;
      res_idx_nxt  = '0;
      res_free_nxt = '0;
      res_used_nxt = '0;
    end

    if (cmd.res_err) begin
      res_st_nxt   = cmd.err_code;
      res_idx_nxt  = '0;
      res_free_nxt = '0;
      res_used_nxt = '0;
    end

    // append at the end of the table
    if (cmd.append) begin
      ram_we       = 1'b1;
      count_nxt    = count_r + CW'(1);
      res_st_nxt   = ST_OK;
      res_idx_nxt  = IW'(count_r);
      res_free_nxt = nfree_r;
      res_used_nxt = nused_r;
    end

    // read back one entry
    if (cmd.rd_issue) begin
      ram_raddr = IW'(ridx_r);
    end
    if (cmd.rd_take) begin
      res_st_nxt   = ST_OK;
      res_idx_nxt  = IW'(ridx_r);
      res_free_nxt = rd_free;
      res_used_nxt = rd_used;
    end

    // next-fit scan from the rover
    if (cmd.scan_start) begin
      rd_ptr_nxt = rover_r;
      issued_nxt = '0;
    end
    if (cmd.scan_step) begin
      if (issue) begin
        rd_ptr_nxt  = (rd_ptr_inc == count_r) ? '0 : IW'(rd_ptr_inc);
        issued_nxt  = issued_r + CW'(1);
        chk_vld_nxt = 1'b1;
        chk_ptr_nxt = rd_ptr_r;
      end
      if (sts.scan_hit) begin
        chk_vld_nxt  = 1'b0;
        ram_we       = 1'b1;
        ram_waddr    = chk_ptr_r;
        ram_wdata    = {free_left, used_sat};
        rover_nxt    = (chk_ptr_inc == count_r) ? '0 : IW'(chk_ptr_inc);
        res_st_nxt   = ST_OK;
        res_idx_nxt  = chk_ptr_r;
        res_free_nxt = free_left;
        res_used_nxt = used_sat;
      end else if (sts.scan_miss) begin
        res_st_nxt   = ST_NOFIT;
        res_idx_nxt  = '0;
        res_free_nxt = '0;
        res_used_nxt = '0;
      end
    end
  end

  // output handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rover_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rover_r     <= rover_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= in_action;
      nfree_r <= in_new_free_len;
      nused_r <= in_new_used_len;
      req_r   <= in_request_size;
      ridx_r  <= in_read_index;
    end
    rd_ptr_r   <= rd_ptr_nxt;
    issued_r   <= issued_nxt;
    chk_ptr_r  <= chk_ptr_nxt;
    res_st_r   <= res_st_nxt;
    res_idx_r  <= res_idx_nxt;
    res_free_r <= res_free_nxt;
    res_used_r <= res_used_nxt;
    if (cmd.push) begin
      out_st_r   <= res_st_r;
      out_idx_r  <= RIDX_W'(res_idx_r);
      out_free_r <= res_free_r;
      out_used_r <= res_used_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_st_r;
  assign out_entry_index    = out_idx_r;
  assign out_entry_free_len = out_free_r;
  assign out_entry_used_len = out_used_r;

endmodule

`default_nettype wire

/* hw/rtl/next_fit_partition_allocator.sv */
// next_fit_partition_allocator: top level joining the sequencer and the table datapath
// depends on nfpa_pkg, nfpa_if, nfpa_ctrl, nfpa_dp (and nfpa_ram below it)
//
// Usage: in_tr carries one action per transaction (clear, append, allocate, read);
// out_tr returns exactly one result transaction for each, in order.
// One transaction is worked on at a time; in_ready is high only while idle.
// A clear, an append and every error case go from decode straight to the output stage;
// a read first waits for the registered ram read, and an allocation scans entries
// from the rover until one fits or all n entries have been checked.
// The scan reads one table entry per cycle through the single ram read port.
// The result sits in an output register; the next item is accepted and worked on
// while it waits, and a finished result waits only if the previous one is untaken.
// Reset (rst_n low, synchronous) empties the table and zeroes the rover; table
// contents are not cleared and are only ever read below the entry count.
`default_nettype none

module next_fit_partition_allocator #(
  parameter int MAX_PARTS = 64
) (
  input wire logic  clk,
  input wire logic  rst_n,
  nfpa_in_if.sink   in_tr,
  nfpa_out_if.source out_tr
);
  import nfpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nfpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tr.valid),
    .in_ready (in_tr.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nfpa_dp #(
    .MAX_PARTS (MAX_PARTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_tr.action),
    .in_new_free_len    (in_tr.new_free_len),
    .in_new_used_len    (in_tr.new_used_len),
    .in_request_size    (in_tr.request_size),
    .in_read_index      (in_tr.read_index),
    .out_valid          (out_tr.valid),
    .out_ready          (out_tr.ready),
    .out_status         (out_tr.status),
    .out_entry_index    (out_tr.entry_index),
    .out_entry_free_len (out_tr.entry_free_len),
    .out_entry_used_len (out_tr.entry_used_len)
  );

endmodule

`default_nettype wire

/* hw/rtl/nfpa_chk.sv */
// nfpa_chk: port-level assertions for next_fit_partition_allocator, bound to the top
// depends on nfpa_pkg for widths and status codes
`default_nettype none

module nfpa_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [nfpa_pkg::ST_W-1:0]   out_status,
  input wire logic [nfpa_pkg::RIDX_W-1:0] out_entry_index,
  input wire logic [nfpa_pkg::LEN_W-1:0]  out_entry_free_len,
  input wire logic [nfpa_pkg::LEN_W-1:0]  out_entry_used_len
);
  import nfpa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_entry_index) && $stable(out_entry_free_len)
      && $stable(out_entry_used_len))
    else $error("stalled result changed");

  // one transaction at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // every failing status carries zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_entry_index == '0) && (out_entry_free_len == '0)
      && (out_entry_used_len == '0))
    else $error("error result with nonzero fields");

  // reset drops the result channel
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind next_fit_partition_allocator nfpa_chk u_nfpa_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_tr.valid),
  .in_ready           (in_tr.ready),
  .out_valid          (out_tr.valid),
  .out_ready          (out_tr.ready),
  .out_status         (out_tr.status),
  .out_entry_index    (out_tr.entry_index),
  .out_entry_free_len (out_tr.entry_free_len),
  .out_entry_used_len (out_tr.entry_used_len)
);

`default_nettype wire

/* sim/next_fit_partition_allocator_tb.sv */
// next_fit_partition_allocator_tb: self-checking bench for the next-fit allocator
// keeps its own copy of the partition table and checks each result transaction
// depends on nfpa_pkg, nfpa_if and the allocator rtl
`timescale 1ns / 100ps

module next_fit_partition_allocator_tb;
  import nfpa_pkg::*;

  localparam int NPARTS    = 64;
  localparam int HALF_PER  = 6;
  localparam int MAX_CYC   = 1000000;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE    = 100;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [LEN_W-1:0]  free_len;
    logic [LEN_W-1:0]  used_len;
    logic [LEN_W-1:0]  req;
    logic [RIDX_W-1:0] ridx;
  } action_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [RIDX_W-1:0] idx;
    logic [LEN_W-1:0]  free_len;
    logic [LEN_W-1:0]  used_len;
  } entry_res_t;

  logic clk;
  logic rst_n;

  nfpa_in_if  in_tr ();
  nfpa_out_if out_tr ();

  next_fit_partition_allocator #(.MAX_PARTS(NPARTS)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_tr (in_tr),
    .out_tr(out_tr)
  );

  // shadow of the partition table
  logic [LEN_W-1:0] tbl_free [NPARTS];
  logic [LEN_W-1:0] tbl_used [NPARTS];
  int unsigned      tbl_count;
  int unsigned      tbl_rover;

  action_t    action_backlog[$];
  entry_res_t due_results[$];

  logic in_fire, out_fire;
  int   in_gap, out_gap, hold_left;
  bit   in_calm, out_calm;
  int   n_results, n_bad, cycle_cnt;
  int   gen_count, n_rand;
  action_t    next_act, seen_act;
  entry_res_t got_res, want_res;

  // apply one action to the shadow table and return the entry it reports
  function automatic entry_res_t apply_action(action_t a);
    entry_res_t  r;
    int unsigned pos;
    int unsigned sum;
    bit          hit;
    r   = '0;
    hit = 0;
    case (a.action)
      ACT_CLEAR: begin
        tbl_count = 0;
        tbl_rover = 0;
        r.status  = ST_OK;
      end
      ACT_APPEND: begin
        if (tbl_count >= NPARTS) begin
          r.status = ST_FULL;
        end else begin
          tbl_free[tbl_count] = a.free_len;
          tbl_used[tbl_count] = a.used_len;
          r = '{ST_OK, tbl_count[RIDX_W-1:0], a.free_len, a.used_len};
          tbl_count++;
        end
      end
      ACT_ALLOC: begin
        if (tbl_count == 0) begin
          r.status = ST_NOFIT;
        end else begin
          pos = tbl_rover % tbl_count;
          for (int unsigned s = 0; s < tbl_count && !hit; s++) begin
            if (tbl_free[pos] >= a.req) begin
              sum = 32'(tbl_used[pos]) + 32'(a.req);
              tbl_free[pos] = tbl_free[pos] - a.req;
              tbl_used[pos] = (sum > 32'(USED_MAX)) ? USED_MAX : sum[LEN_W-1:0];
              tbl_rover = (pos + 1) % tbl_count;
              r = '{ST_OK, pos[RIDX_W-1:0], tbl_free[pos], tbl_used[pos]};
              hit = 1;
            end else begin
              pos = (pos + 1) % tbl_count;
            end
          end
          if (!hit) r.status = ST_NOFIT;
        end
      end
      default: begin
        if (32'(a.ridx) >= tbl_count) begin
          r.status = ST_RANGE;
        end else begin
          r = '{ST_OK, a.ridx, tbl_free[a.ridx], tbl_used[a.ridx]};
        end
      end
    endcase
    return r;
  endfunction

  // length of an appended partition: mostly legal sizes, some above the memory size
  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd128;
      2: return 8'hFF;
      3, 4: return LEN_W'($urandom_range(0, 8));
      5: return LEN_W'($urandom_range(129, 255));
      default: return LEN_W'($urandom_range(0, 128));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] rand_req();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1, 2, 3: return LEN_W'($urandom_range(0, 16));
      4: return LEN_W'($urandom_range(129, 255));
      default: return LEN_W'($urandom_range(0, 128));
    endcase
  endfunction

  // queue one action; fields it does not use carry random values
  task automatic add_action(logic [ACT_W-1:0] act, int a, int b);
    action_t op;
    op.action   = act;
    op.free_len = LEN_W'($urandom);
    op.used_len = LEN_W'($urandom);
    op.req      = LEN_W'($urandom);
    op.ridx     = RIDX_W'($urandom);
    case (act)
      ACT_APPEND: begin
        op.free_len = LEN_W'(a);
        op.used_len = LEN_W'(b);
        if (gen_count < NPARTS) gen_count++;
      end
      ACT_ALLOC: op.req = LEN_W'(a);
      ACT_READ:  op.ridx = RIDX_W'(a);
      default:   gen_count = 0;
    endcase
    action_backlog.push_back(op);
  endtask

  // hold the sender until the block has returned everything
  task automatic drain();
    do begin
      @(negedge clk);
      #1;
    end while (action_backlog.size() != 0 || in_tr.valid || due_results.size() != 0);
  endtask

  task automatic note_mismatch(string what, entry_res_t exp_r, entry_res_t act_r);
    n_bad++;
    if (n_bad <= 10)
      $display("%0t %s: exp st=%0d idx=%0d free=%0d used=%0d, %s%0d %s%0d %s%0d %s%0d",
               $time, what, exp_r.status, exp_r.idx, exp_r.free_len, exp_r.used_len,
               "got st=", act_r.status, "idx=", act_r.idx, "free=", act_r.free_len,
               "used=", act_r.used_len);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #HALF_PER clk = ~clk;
  end

  // input driver: offers the backlog, one transaction at a time
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tr.valid <= 1'b0;
      in_gap = 0;
    end else if (in_tr.valid && !in_fire) begin
      // still waiting for the block to take it
    end else if (in_gap > 0) begin
      in_tr.valid <= 1'b0;
      in_gap--;
    end else if (action_backlog.size() != 0) begin
      next_act = action_backlog.pop_front();
      in_tr.valid        <= 1'b1;
      in_tr.action       <= next_act.action;
      in_tr.new_free_len <= next_act.free_len;
      in_tr.new_used_len <= next_act.used_len;
      in_tr.request_size <= next_act.req;
      in_tr.read_index   <= next_act.ridx;
      if ($urandom_range(0, 29) == 0) in_calm = ~in_calm;
      in_gap = in_calm ? 0 : $urandom_range(0, 10);
    end else begin
      in_tr.valid <= 1'b0;
    end
  end

  // result ready: per-transaction stalls plus two long hold-offs
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tr.ready <= 1'b0;
      out_gap   = 0;
      hold_left = 0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 29) == 0) out_calm = ~out_calm;
        out_gap = out_calm ? 0 : $urandom_range(0, 10);
        if (n_results == 150 || n_results == 600) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_tr.ready <= 1'b0;
        hold_left--;
      end else if (out_gap > 0) begin
        out_tr.ready <= 1'b0;
        out_gap--;
      end else begin
        out_tr.ready <= 1'b1;
      end
    end
  end

  // monitor: predicts on accepted actions, checks accepted results
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    in_fire   <= rst_n && in_tr.valid && in_tr.ready;
    out_fire  <= rst_n && out_tr.valid && out_tr.ready;
    if (rst_n && in_tr.valid && in_tr.ready) begin
      seen_act = '{in_tr.action, in_tr.new_free_len, in_tr.new_used_len,
                   in_tr.request_size, in_tr.read_index};
      due_results.push_back(apply_action(seen_act));
    end
    if (rst_n && out_tr.valid && out_tr.ready) begin
      got_res = '{out_tr.status, out_tr.entry_index, out_tr.entry_free_len,
                  out_tr.entry_used_len};
      if (due_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got_res);
      end else begin
        want_res = due_results.pop_front();
        if (got_res !== want_res) note_mismatch("result mismatch", want_res, got_res);
      end
      n_results++;
    end
    if (cycle_cnt > MAX_CYC) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    rst_n = 1'b0;
    in_tr.valid = 1'b0;
    in_tr.action = ACT_CLEAR;
    in_tr.new_free_len = '0;
    in_tr.new_used_len = '0;
    in_tr.request_size = '0;
    in_tr.read_index = '0;
    out_tr.ready = 1'b0;
    in_fire = 1'b0;
    out_fire = 1'b0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    n_results = 0;
    n_bad = 0;
    cycle_cnt = 0;
    gen_count = 0;
    n_rand = 0;
    tbl_count = 0;
    tbl_rover = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, zero request, saturation, wrap, no fit
    add_action(ACT_ALLOC, 0, 0);
    add_action(ACT_READ, 0, 0);
    add_action(ACT_APPEND, 0, 0);
    add_action(ACT_APPEND, 255, 255);
    add_action(ACT_APPEND, 128, 0);
    add_action(ACT_APPEND, 0, 128);
    add_action(ACT_ALLOC, 0, 0);
    add_action(ACT_ALLOC, 255, 0);
    add_action(ACT_ALLOC, 200, 0);
    add_action(ACT_ALLOC, 100, 0);
    add_action(ACT_APPEND, 200, 200);
    add_action(ACT_ALLOC, 150, 0);
    add_action(ACT_READ, 4, 0);
    add_action(ACT_READ, 63, 0);
    add_action(ACT_READ, 1, 0);
    add_action(ACT_ALLOC, 1, 0);
    add_action(ACT_CLEAR, 0, 0);
    add_action(ACT_READ, 0, 0);
    add_action(ACT_APPEND, 1, 1);
    add_action(ACT_ALLOC, 1, 0);
    add_action(ACT_ALLOC, 1, 0);
    add_action(ACT_READ, 0, 0);
    drain();

    // random: build a table, then work on it with allocations and reads
    while (n_rand < 900) begin
      int n_app;
      int n_ops;
      int base;
      base = action_backlog.size();
      if ($urandom_range(0, 4) != 0) add_action(ACT_CLEAR, 0, 0);
      n_app = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
      repeat (n_app) add_action(ACT_APPEND, int'(rand_len()), int'(rand_len()));
      n_ops = $urandom_range(5, 30);
      repeat (n_ops) begin
        case ($urandom_range(0, 19))
          0, 1: add_action(ACT_APPEND, int'(rand_len()), int'(rand_len()));
          2: add_action(ACT_CLEAR, 0, 0);
          3: add_action(ACT_W'($urandom_range(0, 3)), int'(rand_req()),
                        $urandom_range(0, 255));
          4, 5, 6, 7, 8, 9: begin
            if (gen_count > 0 && $urandom_range(0, 4) != 0)
              add_action(ACT_READ, $urandom_range(0, gen_count - 1), 0);
            else
              add_action(ACT_READ, $urandom_range(0, 63), 0);
          end
          default: add_action(ACT_ALLOC, int'(rand_req()), 0);
        endcase
      end
      n_rand += action_backlog.size() - base;
      if (n_rand % 300 < (action_backlog.size() - base)) drain();
    end
    drain();

    repeat (SETTLE) @(posedge clk);
    if (n_bad == 0 && due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
